### rtl/mlfq_pkg.sv
package mlfq_pkg;

  localparam int LEVELS = 3;
  localparam int TW = 17;
  localparam int AW = 16;
  localparam int BW = 12;
  localparam int LW = 2;

  localparam logic [LW-1:0] LVL_TOP = 2'd0;
  localparam logic [LW-1:0] LVL_MID = 2'd1;
  localparam logic [LW-1:0] LVL_LOW = 2'd2;

  localparam logic [1:0] REG_QTOP = 2'd0;
  localparam logic [1:0] REG_QMID = 2'd1;
  localparam logic [1:0] REG_QLOW = 2'd2;

  typedef struct packed {
    logic          load;
    logic [AW-1:0] arrival;
    logic [BW-1:0] burst;
    logic [TW-1:0] now;
    logic [BW-1:0] quantum;
    logic          shift;
    logic          clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic [LEVELS-1:0] ready;
    logic              fin;
    logic              done_next;
    logic [AW-1:0]     arrival;
    logic [TW-1:0]     turn;
    logic [TW-1:0]     resp;
  } cell_stat_t;

  typedef struct packed {
    logic [TW-1:0] turn;
    logic [TW-1:0] resp;
  } cell_res_t;

endpackage

### rtl/mlfq_cell.sv
module mlfq_cell import mlfq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       load_sel,
  input  logic       run,
  input  cell_res_t  from_next,
  output cell_res_t  to_prev,
  output cell_stat_t stat
);

  logic [AW-1:0] arrival;
  logic [BW-1:0] burst;
  logic [BW-1:0] ticks_run;
  logic [BW-1:0] level_ticks;
  logic [LW-1:0] level;
  logic          fin;
  logic          started;
  logic [TW-1:0] turn;
  logic [TW-1:0] resp;

  logic [BW-1:0] ticks_next;
  logic [BW-1:0] lvt_next;
  logic [BW-1:0] need;
  logic          arrived;

  assign ticks_next = ticks_run + 1'b1;
  assign lvt_next = level_ticks + 1'b1;
  assign need = (burst == '0) ? BW'(1) : burst;
  assign arrived = ({1'b0, arrival} <= ctrl.now);

  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      stat.ready[l] = !fin && (level == LW'(l)) && arrived;
    end
  end
  assign stat.fin = fin;
  assign stat.done_next = (ticks_next >= need);
  assign stat.arrival = arrival;
  assign stat.turn = turn;
  assign stat.resp = resp;
  assign to_prev.turn = turn;
  assign to_prev.resp = resp;

  always_ff @(posedge clk) begin
    if (ctrl.load && load_sel) begin
      arrival <= ctrl.arrival;
      burst <= ctrl.burst;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      ticks_run <= '0;
      level_ticks <= '0;
      level <= LVL_TOP;
      fin <= 1'b0;
      started <= 1'b0;
      turn <= '0;
      resp <= '0;
    end else if (ctrl.shift) begin
      turn <= from_next.turn;
      resp <= from_next.resp;
    end else if (run) begin
      if (!started) begin
        started <= 1'b1;
        resp <= ctrl.now - {1'b0, arrival};
      end
      ticks_run <= ticks_next;
      if (ticks_next >= need) begin
        fin <= 1'b1;
        level_ticks <= lvt_next;
        turn <= ctrl.now + 1'b1 - {1'b0, arrival};
      end else if (lvt_next >= ctrl.quantum) begin
        level_ticks <= '0;
        if (level != LVL_LOW) level <= level + 1'b1;
      end else begin
        level_ticks <= lvt_next;
      end
    end
  end

endmodule

### rtl/mlfq_pick.sv
module mlfq_pick #(
  parameter int N = 16,
  parameter int IW = 4
) (
  input  logic [N-1:0]  req,
  input  logic [IW-1:0] ptr,
  output logic          found,
  output logic [IW-1:0] idx
);

  logic [N-1:0]  masked;
  logic [IW-1:0] idx_m;
  logic [IW-1:0] idx_a;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      masked[i] = req[i] && (i >= int'(ptr));
    end
    idx_m = '0;
    idx_a = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (masked[i]) idx_m = IW'(i);
      if (req[i]) idx_a = IW'(i);
    end
    found = |req;
    idx = (|masked) ? idx_m : idx_a;
  end

endmodule

### rtl/multilevel_feedback_queue_sim_top.sv
// Loading: one job item per cycle while busy is low.
// After the marked item, busy stays high for the simulation: each scheduled tick,
// each scan that jumps over idle time to the earliest pending arrival, and a final step.
// Results then appear one per cycle, one for each loaded job; busy drops with the last one.
// Results cannot be stalled. Synchronous reset restores quanta 10/20/40.
module multilevel_feedback_queue_sim_top import mlfq_pkg::*; #(
  parameter int MAX_JOBS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] job_arrival,
  input  logic [11:0] job_burst,
  input  logic        last_job,
  output logic        result_valid,
  output logic [3:0]  job_number,
  output logic [16:0] turnaround,
  output logic [16:0] response,
  output logic        last_result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW = $clog2(MAX_JOBS + 1);

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]    state;
  logic [BW-1:0] quantum_top, quantum_mid, quantum_low;
  logic [CW-1:0] job_count;
  logic [CW-1:0] remaining;
  logic [TW-1:0] sim_time;
  logic [IW-1:0] level_pointer [LEVELS];
  logic [IW-1:0] k;
  logic          any;
  logic [AW-1:0] min_arr;

  cell_ctrl_t    ctrl;
  cell_stat_t    stat [MAX_JOBS];
  cell_res_t     chain [MAX_JOBS+1];
  logic [MAX_JOBS-1:0] run_vec;
  logic [MAX_JOBS-1:0] ready_l [LEVELS];
  logic [LEVELS-1:0]   found_l;
  logic [IW-1:0]       idx_l [LEVELS];

  logic          accept;
  logic          pick;
  logic [LW-1:0] lv;
  logic [IW-1:0] c;
  logic [BW-1:0] q_raw;
  logic          cand;
  logic          wr;

  assign pready = 1'b1;
  assign busy = (state != S_LOAD);
  assign accept = start && !busy;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum_top <= 12'd10;
      quantum_mid <= 12'd20;
      quantum_low <= 12'd40;
    end else if (wr) begin
      case (paddr[3:2])
        REG_QTOP: quantum_top <= pwdata[BW-1:0];
        REG_QMID: quantum_mid <= pwdata[BW-1:0];
        REG_QLOW: quantum_low <= pwdata[BW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_QTOP: prdata = {20'd0, quantum_top};
      REG_QMID: prdata = {20'd0, quantum_mid};
      REG_QLOW: prdata = {20'd0, quantum_low};
      default:  prdata = '0;
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < MAX_JOBS; g++) begin : g_cell
      for (genvar l = 0; l < LEVELS; l++) begin : g_rdy
        assign ready_l[l][g] = stat[g].ready[l] && (job_count > CW'(g));
      end
      mlfq_cell u_cell (
        .clk(clk), .rst(rst), .ctrl(ctrl),
        .load_sel(job_count == CW'(g)),
        .run(run_vec[g]),
        .from_next(chain[g+1]),
        .to_prev(chain[g]),
        .stat(stat[g])
      );
    end
    for (g = 0; g < LEVELS; g++) begin : g_pick
      mlfq_pick #(.N(MAX_JOBS), .IW(IW)) u_pick (
        .req(ready_l[g]), .ptr(level_pointer[g]),
        .found(found_l[g]), .idx(idx_l[g])
      );
    end
  endgenerate
  assign chain[MAX_JOBS] = '0;

  always_comb begin
    pick = |found_l;
    if (found_l[0]) begin
      lv = LVL_TOP; c = idx_l[0]; q_raw = quantum_top;
    end else if (found_l[1]) begin
      lv = LVL_MID; c = idx_l[1]; q_raw = quantum_mid;
    end else begin
      lv = LVL_LOW; c = idx_l[2]; q_raw = quantum_low;
    end
  end

  always_comb begin
    ctrl.load = accept && (job_count < CW'(MAX_JOBS));
    ctrl.arrival = job_arrival;
    ctrl.burst = job_burst;
    ctrl.now = sim_time;
    ctrl.quantum = (q_raw == '0) ? BW'(1) : q_raw;
    ctrl.shift = (state == S_OUT) && (CW'(k) + 1'b1 != job_count);
    ctrl.clear = (state == S_OUT) && (CW'(k) + 1'b1 == job_count);
    for (int i = 0; i < MAX_JOBS; i++) begin
      run_vec[i] = (state == S_RUN) && (remaining != '0) && pick && (c == IW'(i));
    end
  end

  assign cand = !stat[k].fin && (!any || stat[k].arrival < min_arr);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      job_count <= '0;
      remaining <= '0;
      sim_time <= '0;
      k <= '0;
      any <= 1'b0;
      result_valid <= 1'b0;
      for (int l = 0; l < LEVELS; l++) level_pointer[l] <= '0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (ctrl.load) job_count <= job_count + 1'b1;
            if (last_job) begin
              state <= S_RUN;
              remaining <= ctrl.load ? job_count + 1'b1 : job_count;
            end
          end
        end
        S_RUN: begin
          if (remaining == '0) begin
            state <= S_OUT;
            k <= '0;
          end else if (pick) begin
            sim_time <= sim_time + 1'b1;
            if (stat[c].done_next) remaining <= remaining - 1'b1;
            level_pointer[lv] <= (CW'(c) + 1'b1 == job_count) ? '0 : c + 1'b1;
          end else begin
            state <= S_SCAN;
            k <= '0;
            any <= 1'b0;
          end
        end
        S_SCAN: begin
          if (cand) begin
            min_arr <= stat[k].arrival;
            any <= 1'b1;
          end
          if (CW'(k) + 1'b1 == job_count) begin
            sim_time <= {1'b0, cand ? stat[k].arrival : min_arr};
            state <= S_RUN;
          end
          k <= k + 1'b1;
        end
        S_OUT: begin
          result_valid <= 1'b1;
          job_number <= 4'(k);
          turnaround <= stat[0].turn;
          response <= stat[0].resp;
          last_result <= (CW'(k) + 1'b1 == job_count);
          k <= k + 1'b1;
          if (CW'(k) + 1'b1 == job_count) begin
            state <= S_LOAD;
            job_count <= '0;
            sim_time <= '0;
            for (int l = 0; l < LEVELS; l++) level_pointer[l] <= '0;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule
